/* rtl/csc_pkg.sv */
`default_nettype none

package csc_pkg;

   // Field widths.
   localparam int KIND_W  = 2;
   localparam int REV_W   = 16;
   localparam int TIME_W  = 16;
   localparam int VAL_W   = 16;
   localparam int TICKS_W = 16;

   // Datapath widths. The speed numerator is revs*T*3600*pi*diam, below 2^76;
   // after the Q2.14 * Q8.8 fraction (22 bits) is dropped it fits 54 bits.
   localparam int PROD_W     = REV_W + TICKS_W;  // revs * ticks
   localparam int SCALE_W    = PROD_W + 12;      // times 3600 or 60
   localparam int HALF_W     = SCALE_W / 2;      // split for partial products
   localparam int B_W        = 32;               // pi * diameter
   localparam int PART_W     = HALF_W + B_W;     // one partial product
   localparam int FRAC_SHIFT = 22;
   localparam int NUM_W      = 54;
   localparam int DEN_W      = 26;               // 1000 * dt
   localparam int QUOT_W     = VAL_W;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int CNT_W      = 4;

   localparam logic [15:0] PI_Q14       = 16'd51472;
   localparam logic [11:0] SEC_PER_MIN  = 12'd60;
   localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
   localparam logic [9:0]  CM_SCALE     = 10'd1000;
   localparam logic [VAL_W-1:0] VALUE_MAX = 16'hffff;

   // Measurement kinds on the input; the other codes are not defined.
   localparam logic [KIND_W-1:0] KIND_SPEED   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CADENCE = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_REV,
      ST_MUL_SCALE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SETUP,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_rev;
      logic mul_scale;
      logic mul_lo;
      logic mul_hi;
      logic setup;
      logic div_step;
      logic write_out;
   } cmd_type;

   typedef struct packed {
      logic skip;      // result is known to be zero: zero delta or unknown kind
      logic cadence;   // current item is a cadence measurement
   } status_type;

endpackage

`default_nettype wire

/* rtl/cycling_speed_cadence_calc.sv */
// Cycling speed and cadence calculator.
// Input words arrive on the req_ stream: tuser carries the measurement kind
// (speed, cadence or an unknown code) and tdata the cumulative revolution
// count and the event time in 1/TICKS_PER_SECOND s ticks. Each input word
// yields exactly one output word on the rsp_ stream: tuser is the channel,
// tdata the value (km/h*100 for speed, rpm for cadence) with saturation and
// unknown-kind flags. The wheel diameter (Q8.8 cm) is written through csr_.
// Speed words pass the revolution and scale multiplies, two partial products
// and the divider; cadence words skip the partial products, and a zero delta
// or unknown kind goes straight to the write. One word is in flight at a
// time: the input is ready again once the result is in the output register.
// The 16-step restoring divider yields one quotient bit per cycle.
// While a result waits in the output register the next word is accepted and
// computed; only its final write waits for the receiver to take the old one.
// Reset clears the diameter, the per-channel history and the output valid.
`default_nettype none

module cycling_speed_cadence_calc #(
   parameter int TICKS_PER_SECOND = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data,   // wheel_diameter
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,     // [15:0] cumulative_revs, [31:16] event_time
   input  wire  [1:0]  req_tuser,     // [1:0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,     // [15:0] value, [16] saturated, [17] unknown_kind
   output logic        rsp_tuser      // [0] channel
);

   csc_pkg::cmd_type    cmd;
   csc_pkg::status_type status;

   logic                        out_channel;
   logic [csc_pkg::VAL_W-1:0]   out_value;
   logic                        out_saturated;
   logic                        out_unknown;

   // Sequencer: walks each word through the multiply and divide steps.
   csc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: history, deltas, partial products, divider and output register.
   csc_dp #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .in_kind       (req_tuser),
      .in_revs       (req_tdata[15:0]),
      .in_time       (req_tdata[31:16]),
      .cmd           (cmd),
      .status        (status),
      .out_channel   (out_channel),
      .out_value     (out_value),
      .out_saturated (out_saturated),
      .out_unknown   (out_unknown)
   );

   assign rsp_tdata = {6'b0, out_unknown, out_saturated, out_value};
   assign rsp_tuser = out_channel;

`ifndef NO_ASSERTIONS
   // The block works on one word at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready while a word is in progress");

   // An unknown kind reports a cleared result on channel zero.
   a_unknown_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |->
         rsp_tdata[15:0] == 16'd0 && !rsp_tdata[16] && !rsp_tuser)
      else $error("unknown kind result not cleared");

   // A saturated result carries the full-scale value.
   a_sat_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15:0] == 16'hffff)
      else $error("saturated result without full-scale value");
`endif

endmodule

`default_nettype wire

/* rtl/csc_ctrl.sv */
`default_nettype none

module csc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  csc_pkg::status_type   status,
   output csc_pkg::cmd_type      cmd
);

   csc_pkg::state_type state_ff, state_in;
   logic [csc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         csc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = csc_pkg::ST_MUL_REV;
            end
         end
         csc_pkg::ST_MUL_REV: begin
            cmd.mul_rev = 1'b1;
            state_in    = status.skip ? csc_pkg::ST_WRITE : csc_pkg::ST_MUL_SCALE;
         end
         csc_pkg::ST_MUL_SCALE: begin
            cmd.mul_scale = 1'b1;
            state_in      = status.cadence ? csc_pkg::ST_SETUP : csc_pkg::ST_MUL_LO;
         end
         csc_pkg::ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = csc_pkg::ST_MUL_HI;
         end
         csc_pkg::ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = csc_pkg::ST_SETUP;
         end
         csc_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = csc_pkg::ST_DIVIDE;
         end
         csc_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == csc_pkg::CNT_W'(csc_pkg::DIV_STEPS - 1)) begin
               state_in = csc_pkg::ST_WRITE;
            end
         end
         csc_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.write_out = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = csc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/csc_dp.sv */
`default_nettype none

module csc_dp #(
   parameter int TICKS_PER_SECOND = 1024
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_wr_en,
   input  wire  [csc_pkg::VAL_W-1:0]         csr_wr_data,
   input  wire  [csc_pkg::KIND_W-1:0]        in_kind,
   input  wire  [csc_pkg::REV_W-1:0]         in_revs,
   input  wire  [csc_pkg::TIME_W-1:0]        in_time,
   input  csc_pkg::cmd_type                  cmd,
   output csc_pkg::status_type               status,
   output logic                              out_channel,
   output logic [csc_pkg::VAL_W-1:0]         out_value,
   output logic                              out_saturated,
   output logic                              out_unknown
);

   localparam logic [csc_pkg::TICKS_W-1:0] TICKS = csc_pkg::TICKS_W'(TICKS_PER_SECOND);

   // Wheel diameter register, Q8.8 cm.
   logic [csc_pkg::VAL_W-1:0] diam_ff;

   // Per-channel history.
   logic [csc_pkg::REV_W-1:0]  speed_revs_ff, cad_revs_ff;
   logic [csc_pkg::TIME_W-1:0] speed_time_ff, cad_time_ff;

   // Current item.
   logic [csc_pkg::REV_W-1:0]  dr_ff;
   logic [csc_pkg::TIME_W-1:0] dt_ff;
   logic chan_ff, unk_ff, skip_ff;

   // Arithmetic registers.
   logic [csc_pkg::PROD_W-1:0]  prod_ff;
   logic [csc_pkg::B_W-1:0]     b_ff;
   logic [csc_pkg::SCALE_W-1:0] a_ff;
   logic [csc_pkg::DEN_W-1:0]   den_ff;
   logic [csc_pkg::PART_W-1:0]  p0_ff, p1_ff;
   logic [csc_pkg::DEN_W-1:0]   rem_ff;
   logic [csc_pkg::QUOT_W-1:0]  shift_ff;
   logic sat_ff;

   // Deltas of the arriving item against its channel's history.
   logic [csc_pkg::REV_W-1:0]  load_dr;
   logic [csc_pkg::TIME_W-1:0] load_dt;
   logic load_chan, load_unk;

   always_comb begin
      load_dr   = '0;
      load_dt   = '0;
      load_chan = 1'b0;
      load_unk  = 1'b0;
      unique case (in_kind)
         csc_pkg::KIND_SPEED: begin
            load_dr = in_revs - speed_revs_ff;
            load_dt = in_time - speed_time_ff;
         end
         csc_pkg::KIND_CADENCE: begin
            load_dr   = in_revs - cad_revs_ff;
            load_dt   = in_time - cad_time_ff;
            load_chan = 1'b1;
         end
         default: begin
            load_unk = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diam_ff       <= '0;
         speed_revs_ff <= '0;
         speed_time_ff <= '0;
         cad_revs_ff   <= '0;
         cad_time_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            diam_ff <= csr_wr_data;
         end
         if (cmd.load && in_kind == csc_pkg::KIND_SPEED) begin
            speed_revs_ff <= in_revs;
            speed_time_ff <= in_time;
         end
         if (cmd.load && in_kind == csc_pkg::KIND_CADENCE) begin
            cad_revs_ff <= in_revs;
            cad_time_ff <= in_time;
         end
      end
   end

   // Numerator of the division. For speed the 22 fraction bits of the product
   // are dropped first; floor of a floor gives the same quotient.
   logic [csc_pkg::NUM_W-1:0] num;
   assign num = chan_ff ? csc_pkg::NUM_W'(a_ff)
                        : p1_ff + csc_pkg::NUM_W'(p0_ff >> csc_pkg::FRAC_SHIFT);

   // One restoring division step.
   logic [csc_pkg::DEN_W:0]   trial;
   logic                      fits;
   logic [csc_pkg::DEN_W-1:0] rem_next;
   assign trial    = {rem_ff, shift_ff[csc_pkg::QUOT_W-1]};
   assign fits     = trial >= {1'b0, den_ff};
   assign rem_next = fits ? csc_pkg::DEN_W'(trial - {1'b0, den_ff})
                          : trial[csc_pkg::DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dr_ff   <= load_dr;
         dt_ff   <= load_dt;
         chan_ff <= load_chan;
         unk_ff  <= load_unk;
         skip_ff <= load_unk || load_dr == '0 || load_dt == '0;
      end
      if (cmd.mul_rev) begin
         prod_ff <= csc_pkg::PROD_W'(dr_ff) * csc_pkg::PROD_W'(TICKS);
         b_ff    <= csc_pkg::B_W'(csc_pkg::PI_Q14) * csc_pkg::B_W'(diam_ff);
      end
      if (cmd.mul_scale) begin
         a_ff   <= csc_pkg::SCALE_W'(prod_ff) * csc_pkg::SCALE_W'(
                      chan_ff ? csc_pkg::SEC_PER_MIN : csc_pkg::SEC_PER_HOUR);
         den_ff <= chan_ff ? csc_pkg::DEN_W'(dt_ff)
                           : csc_pkg::DEN_W'(dt_ff) * csc_pkg::DEN_W'(csc_pkg::CM_SCALE);
      end
      if (cmd.mul_lo) begin
         p0_ff <= csc_pkg::PART_W'(a_ff[csc_pkg::HALF_W-1:0]) * csc_pkg::PART_W'(b_ff);
      end
      if (cmd.mul_hi) begin
         p1_ff <= csc_pkg::PART_W'(a_ff[csc_pkg::SCALE_W-1:csc_pkg::HALF_W])
                  * csc_pkg::PART_W'(b_ff);
      end
      if (cmd.setup) begin
         // The quotient overflows 16 bits exactly when the upper part of the
         // numerator already reaches the divisor.
         sat_ff   <= num[csc_pkg::NUM_W-1:csc_pkg::QUOT_W]
                     >= (csc_pkg::NUM_W - csc_pkg::QUOT_W)'(den_ff);
         rem_ff   <= num[csc_pkg::QUOT_W+csc_pkg::DEN_W-1:csc_pkg::QUOT_W];
         shift_ff <= num[csc_pkg::QUOT_W-1:0];
      end
      if (cmd.div_step) begin
         rem_ff   <= rem_next;
         shift_ff <= {shift_ff[csc_pkg::QUOT_W-2:0], fits};
      end
      if (cmd.write_out) begin
         out_channel   <= chan_ff;
         out_unknown   <= unk_ff;
         out_saturated <= !skip_ff && sat_ff;
         out_value     <= skip_ff ? '0 : (sat_ff ? csc_pkg::VALUE_MAX : shift_ff);
      end
   end

   assign status.skip    = skip_ff;
   assign status.cadence = chan_ff;

endmodule

`default_nettype wire

/* test/tb_cycling_speed_cadence_calc.sv */
`timescale 1ns / 1ps

// Testbench for the cycling speed and cadence calculator.
//
// Measurement words go in on the req_ stream and every one of them must come
// back as exactly one result word on the rsp_ stream, in order. The bench
// keeps its own copy of the per-channel history and of the wheel diameter.
// When an input word is taken it works out the expected result and queues it.
// The checker pops the oldest expectation for every result word and compares
// the channel, value, saturation flag and unknown-kind flag one by one.
//
// The run covers a directed sequence first: zero deltas, wraparound, saturation,
// truncation to zero, unknown kinds leaving the history alone, and the reset
// diameter of zero. Random rides follow under several diameter settings,
// including both extremes of the register. Most of the random words continue
// the stored history with plausible increments, so the results are real
// speeds and cadences. Some are short bursts that saturate or hit a zero
// delta, and the rest are plain noise. Both sides idle at random, except in
// one back-to-back stretch. In one stretch the receiver holds off long enough
// that the block fills up and stalls its input.
`default_nettype none

module tb_cycling_speed_cadence_calc;

   localparam int TICKS_PER_SECOND = 1024;
   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 11;
   // This margin lets any word still in flight through the block show up
   // before the next step.
   localparam int SETTLE_CYCLES    = 40;
   localparam int IDLE_PERCENT     = 19;
   localparam int HOLD_CYCLES      = 400;

   // Arithmetic constants of the speed and cadence formulas.
   localparam logic [31:0] PI_FIX        = 32'd51472;  // pi in Q2.14
   localparam logic [31:0] SEC_HOUR      = 32'd3600;
   localparam logic [31:0] SEC_MINUTE    = 32'd60;
   localparam logic [31:0] SPEED_DIVISOR = 32'd1000;
   localparam int          FRAC_BITS     = 22;         // Q2.14 times Q8.8
   localparam logic [15:0] VALUE_LIMIT   = 16'hffff;

   // The two measurement kinds come from the package. The block has to flag
   // the remaining codes.
   localparam logic [1:0] KIND_SPEED     = csc_pkg::KIND_SPEED;
   localparam logic [1:0] KIND_CADENCE   = csc_pkg::KIND_CADENCE;
   localparam logic [1:0] KIND_UNKNOWN_A = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN_B = 2'd3;

   localparam logic CH_SPEED   = 1'b0;
   localparam logic CH_CADENCE = 1'b1;

   // Diameters in Q8.8 centimetres.
   localparam logic [15:0] DIAM_70CM = 16'd17920;
   localparam logic [15:0] DIAM_MAX  = 16'hffff;
   localparam logic [15:0] DIAM_ZERO = 16'h0000;
   localparam logic [15:0] DIAM_1LSB = 16'h0001;

   typedef struct packed {
      logic        channel;
      logic [15:0] value;
      logic        saturated;
      logic        unknown_kind;
   } csc_result_type;

   // Block ports. Every input has a known value from time zero.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   wire         req_tready;
   logic [31:0] req_tdata   = '0;     // [15:0] cumulative_revs, [31:16] event_time
   logic [1:0]  req_tuser   = '0;     // [1:0] kind
   wire         rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   wire  [23:0] rsp_tdata;            // [15:0] value, [16] saturated, [17] unknown_kind
   wire         rsp_tuser;            // [0] channel

   // These copies of the block's state are updated when a word is accepted or the diameter is written.
   logic [15:0] wheel_diam;
   logic [15:0] speed_prev_revs;
   logic [15:0] speed_prev_time;
   logic [15:0] cadence_prev_revs;
   logic [15:0] cadence_prev_time;

   csc_result_type pending_results[$];

   // Shared controls of the stimulus processes.
   bit steady       = 1'b0;   // no idling on either side
   int hold_request = 0;      // receiver hold-off, picked up by the receiver

   // Bookkeeping for the summary and the verdict.
   int error_count  = 0;
   int n_words      = 0;
   int n_speed      = 0;
   int n_cadence    = 0;
   int n_unknown    = 0;
   int n_saturated  = 0;
   int n_diameters  = 0;
   int n_results    = 0;

   cycling_speed_cadence_calc #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Speed in km/h*100. The product goes up to about 2^76, so an 80-bit
   // numerator keeps it exact. The quotient saturates above 16 bits.
   function automatic logic [16:0] speed_value(input logic [15:0] d_revs,
                                               input logic [15:0] d_time);
      logic [79:0] numer;
      logic [79:0] denom;
      logic [79:0] quot;
      if (d_revs == '0 || d_time == '0) return '0;
      numer = 80'(d_revs) * TICKS_PER_SECOND * SEC_HOUR * PI_FIX * wheel_diam;
      denom = (80'(d_time) * SPEED_DIVISOR) << FRAC_BITS;
      quot  = numer / denom;
      if (quot > 80'(VALUE_LIMIT)) return {1'b1, VALUE_LIMIT};
      return {1'b0, quot[15:0]};
   endfunction

   // Cadence in rpm, saturated the same way.
   function automatic logic [16:0] cadence_value(input logic [15:0] d_revs,
                                                 input logic [15:0] d_time);
      logic [63:0] quot;
      if (d_revs == '0 || d_time == '0) return '0;
      quot = 64'(d_revs) * SEC_MINUTE * TICKS_PER_SECOND / 64'(d_time);
      if (quot > 64'(VALUE_LIMIT)) return {1'b1, VALUE_LIMIT};
      return {1'b0, quot[15:0]};
   endfunction

   // Expected result of one accepted measurement. The history is updated the
   // way the block updates it, and an unknown kind leaves it untouched.
   function automatic csc_result_type predict_measurement(input logic [1:0]  kind,
                                                          input logic [15:0] revs,
                                                          input logic [15:0] etime);
      csc_result_type res;
      logic [15:0] d_revs;
      logic [15:0] d_time;
      res = '0;
      case (kind)
         KIND_SPEED: begin
            d_revs = revs - speed_prev_revs;
            d_time = etime - speed_prev_time;
            speed_prev_revs = revs;
            speed_prev_time = etime;
            {res.saturated, res.value} = speed_value(d_revs, d_time);
            res.channel = CH_SPEED;
            n_speed++;
         end
         KIND_CADENCE: begin
            d_revs = revs - cadence_prev_revs;
            d_time = etime - cadence_prev_time;
            cadence_prev_revs = revs;
            cadence_prev_time = etime;
            {res.saturated, res.value} = cadence_value(d_revs, d_time);
            res.channel = CH_CADENCE;
            n_cadence++;
         end
         default: begin
            res.unknown_kind = 1'b1;
            n_unknown++;
         end
      endcase
      if (res.saturated) n_saturated++;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one measurement word. The word is predicted at the edge where it is
   // taken. tvalid stays high after that edge, so the next call can follow
   // back to back. Whatever idles the stream afterwards lowers it.
   task automatic send_measurement(input logic [1:0]  kind,
                                   input logic [15:0] revs,
                                   input logic [15:0] etime);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {etime, revs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_measurement(kind, revs, etime));
      n_words++;
   endtask

   // Build one random measurement. Most words carry on from the channel's
   // stored history like a real rider. Some are bursts of revolutions in
   // almost no time, which saturate or give a zero time delta. The rest are
   // arbitrary words that exercise every bit of the fields.
   task automatic send_random_measurement();
      logic [1:0]  kind;
      logic [15:0] revs;
      logic [15:0] etime;
      logic [15:0] base_revs;
      logic [15:0] base_time;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 45) kind = KIND_SPEED;
      else if (pick < 90) kind = KIND_CADENCE;
      else kind = $urandom_range(1) ? KIND_UNKNOWN_A : KIND_UNKNOWN_B;
      base_revs = (kind == KIND_CADENCE) ? cadence_prev_revs : speed_prev_revs;
      base_time = (kind == KIND_CADENCE) ? cadence_prev_time : speed_prev_time;
      pick = $urandom_range(99);
      if (pick < 70) begin
         revs  = base_revs + 16'($urandom_range(0, 4));
         etime = base_time + 16'($urandom_range(1, 4096));
      end else if (pick < 85) begin
         revs  = base_revs + 16'($urandom_range(1, 300));
         etime = base_time + 16'($urandom_range(0, 8));
      end else begin
         revs  = 16'($urandom);
         etime = 16'($urandom);
      end
      send_measurement(kind, revs, etime);
   endtask

   // Idle the input and wait until every expected result has arrived, then
   // allow the block's latency to pass so that it is idle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The diameter is only changed while nothing is in flight.
   task automatic write_wheel_diameter(input logic [15:0] diam);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= diam;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      wheel_diam = diam;
      n_diameters++;
   endtask

   // The receiver idles at random, as often as the sender does. A hold-off
   // request holds it low for a counted stretch, and in steady mode it never
   // stalls.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR at %0t ns: %s", $realtime, msg);
   endtask

   // Values are sampled at the rising edge, before anything driven at that
   // edge takes effect, so the outcome does not depend on process order.
   always @(posedge clock) begin : check_results
      csc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected: ch %0d value %0d",
                                      rsp_tuser, rsp_tdata[15:0]));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.channel)
               report_mismatch($sformatf("result %0d channel %0d, expected %0d",
                                         n_results, rsp_tuser, want.channel));
            if (rsp_tdata[15:0] !== want.value)
               report_mismatch($sformatf("result %0d value %0d, expected %0d",
                                         n_results, rsp_tdata[15:0], want.value));
            if (rsp_tdata[16] !== want.saturated)
               report_mismatch($sformatf("result %0d saturated %0d, expected %0d",
                                         n_results, rsp_tdata[16], want.saturated));
            if (rsp_tdata[17] !== want.unknown_kind)
               report_mismatch($sformatf("result %0d unknown_kind %0d, expected %0d",
                                         n_results, rsp_tdata[17], want.unknown_kind));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Hand-picked words. Each one relies on the history left by the words
   // before it, so the order matters.
   task automatic test_directed_cases();
      // Reset diameter is zero: the speed is zero, but the history moves on.
      send_measurement(KIND_SPEED, 16'd5, 16'd100);
      write_wheel_diameter(DIAM_70CM);
      // One revolution in one second.
      send_measurement(KIND_SPEED, 16'd6, 16'd1124);
      // Both deltas zero, then only the time delta, then only the revolutions.
      send_measurement(KIND_SPEED, 16'd6, 16'd1124);
      send_measurement(KIND_SPEED, 16'd7, 16'd1124);
      send_measurement(KIND_SPEED, 16'd7, 16'd2148);
      // One tick apart: far beyond 16 bits, so it saturates.
      send_measurement(KIND_SPEED, 16'd8, 16'd2149);
      // Large forward step, then both counters wrap past 65535.
      send_measurement(KIND_SPEED, 16'hffff, 16'hff00);
      send_measurement(KIND_SPEED, 16'h0002, 16'h0100);
      // Cadence starts from its own zero history, independent of speed.
      send_measurement(KIND_CADENCE, 16'h0000, 16'h0000);
      send_measurement(KIND_CADENCE, 16'd1, 16'd1024);
      send_measurement(KIND_CADENCE, 16'hffff, 16'hffff);
      send_measurement(KIND_CADENCE, 16'h0009, 16'h0000);
      // Unknown kinds with all-ones and all-zeros fields must not disturb
      // either history; the next speed and cadence words prove that.
      send_measurement(KIND_UNKNOWN_A, 16'hffff, 16'hffff);
      send_measurement(KIND_UNKNOWN_B, 16'h0000, 16'h0000);
      send_measurement(KIND_SPEED, 16'h0004, 16'h0500);
      send_measurement(KIND_CADENCE, 16'h000a, 16'h0400);
      // Largest revolution delta for speed, at a very long time delta.
      send_measurement(KIND_SPEED, 16'h0003, 16'h0400);
      // Largest revolution delta over a single tick, then one revolution
      // over the longest time, which truncates to zero rpm.
      send_measurement(KIND_CADENCE, 16'h0009, 16'h0401);
      send_measurement(KIND_CADENCE, 16'h000a, 16'h0400);
   endtask

   // The register's extremes and the smallest non-zero step.
   task automatic test_diameter_extremes();
      write_wheel_diameter(DIAM_ZERO);
      repeat (8) send_random_measurement();
      write_wheel_diameter(DIAM_MAX);
      repeat (10) send_random_measurement();
      write_wheel_diameter(DIAM_1LSB);
      repeat (8) send_random_measurement();
   endtask

   // The bulk of the traffic, with a few typical wheels and one arbitrary
   // register value.
   task automatic test_random_rides();
      logic [15:0] diam;
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) diam = 16'($urandom);
         else diam = 16'($urandom_range(12800, 25600));   // 50 cm to 100 cm
         write_wheel_diameter(diam);
         repeat (100) send_random_measurement();
      end
   endtask

   // Back to back on both sides, with no idle cycles at all.
   task automatic test_steady_stream();
      write_wheel_diameter(DIAM_70CM);
      steady = 1'b1;
      repeat (120) send_random_measurement();
      wait_drained();
      steady = 1'b0;
   endtask

   // The receiver holds off while the sender keeps offering words. One result
   // sits in the output register, the next one waits behind it, and then
   // req_tready has to drop until the receiver takes results again.
   task automatic test_output_backpressure();
      wait_drained();
      hold_request = HOLD_CYCLES;
      repeat (12) send_random_measurement();
   endtask

   initial begin
      wheel_diam        = '0;
      speed_prev_revs   = '0;
      speed_prev_time   = '0;
      cadence_prev_revs = '0;
      cadence_prev_time = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_diameter_extremes();
      test_random_rides();
      test_steady_stream();
      test_output_backpressure();
      wait_drained();

      $display("Run covered %0d measurement words (%0d speed, %0d cadence, %0d unknown kind),",
               n_words, n_speed, n_cadence, n_unknown);
      $display("%0d saturated results, %0d diameter settings, a steady stream and a %0d-cycle stall.",
               n_saturated, n_diameters, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("** cycling_speed_cadence_calc: PASSED **");
      end else begin
         $display("** cycling_speed_cadence_calc: FAILED **");
      end
      $finish;
   end

   // A correct run needs well under a tenth of this time, even with every
   // word waiting out the longest stalls on both sides.
   initial begin
      #5_000_000;
      $display("Timeout: %0d results still expected", pending_results.size());
      $display("** cycling_speed_cadence_calc: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/csc_pkg.sv
rtl/csc_ctrl.sv
rtl/csc_dp.sv
rtl/cycling_speed_cadence_calc.sv
test/tb_cycling_speed_cadence_calc.sv
